// File: hdl/lsie_pkg.sv
// lsie_pkg: types, codes and constants shared by the LED sequencer
// instruction execute block. No dependencies.
`default_nettype none

package lsie_pkg;

    // data memory and program size
    localparam int unsigned MEM_DEPTH  = 256;
    localparam int unsigned MEM_AW     = $clog2(MEM_DEPTH);
    localparam int unsigned PROG_DEPTH = 1024;

    localparam logic [31:0] MEM_DEPTH_W  = 32'(MEM_DEPTH);
    localparam logic [31:0] PROG_DEPTH_W = 32'(PROG_DEPTH);
    localparam logic [31:0] SLEEP_SCALE  = 32'd10;

    // instruction function codes
    typedef enum logic [3:0] {
        FN_LED    = 4'd0,
        FN_JMP    = 4'd1,
        FN_LNJMP  = 4'd2,
        FN_ABSJMP = 4'd3,
        FN_CMP    = 4'd4,
        FN_STORE  = 4'd5,
        FN_ADD    = 4'd6,
        FN_SUB    = 4'd7,
        FN_MUL    = 4'd8,
        FN_DBG    = 4'd9,
        FN_SHOW   = 4'd10,
        FN_SLEEP  = 4'd11,
        FN_RAND   = 4'd12
    } func_t;

    // execute sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD4,
        ST_FIN
    } state_t;

    // one instruction word
    typedef struct packed {
        logic [3:0]         func;
        logic               indirect;
        logic [7:0]         target;
        logic signed [31:0] operand;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               forward;
        logic               conditional;
        logic [7:0]         random_value;
    } item_t;

    // one result word
    typedef struct packed {
        logic [9:0]         next_pc;
        logic               halted;
        logic               led_write;
        logic [7:0]         led_index;
        logic [7:0]         led_red;
        logic [7:0]         led_green;
        logic [7:0]         led_blue;
        logic               show_strip;
        logic [31:0]        sleep_ticks;
        logic               debug_valid;
        logic signed [31:0] debug_value;
    } res_t;

    // data memory access request from the sequencer
    typedef struct packed {
        logic        rd_en;
        logic [31:0] rd_addr;
        logic        wr_en;
        logic [31:0] wr_addr;
        logic [31:0] wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

// File: hdl/lsie_if.sv
// lsie_if: valid/ready channel interfaces for instruction, result and
// configuration words. No dependencies.
`default_nettype none

interface lsie_item_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic               indirect;
    logic [7:0]         target;
    logic signed [31:0] operand;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               forward;
    logic               conditional;
    logic [7:0]         random_value;

    modport source (
        output valid, func, indirect, target, operand, red, green, blue,
               forward, conditional, random_value,
        input  ready
    );
    modport sink (
        input  valid, func, indirect, target, operand, red, green, blue,
               forward, conditional, random_value,
        output ready
    );
endinterface

interface lsie_result_if;
    logic               valid;
    logic               ready;
    logic [9:0]         next_pc;
    logic               halted;
    logic               led_write;
    logic [7:0]         led_index;
    logic [7:0]         led_red;
    logic [7:0]         led_green;
    logic [7:0]         led_blue;
    logic               show_strip;
    logic [31:0]        sleep_ticks;
    logic               debug_valid;
    logic signed [31:0] debug_value;

    modport source (
        output valid, next_pc, halted, led_write, led_index, led_red, led_green,
               led_blue, show_strip, sleep_ticks, debug_valid, debug_value,
        input  ready
    );
    modport sink (
        input  valid, next_pc, halted, led_write, led_index, led_red, led_green,
               led_blue, show_strip, sleep_ticks, debug_valid, debug_value,
        output ready
    );
endinterface

interface lsie_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/lsie_ram.sv
// lsie_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies.
`default_nettype none

module lsie_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/lsie_dmem.sv
// lsie_dmem: data memory with per-entry valid bits (unwritten entries read
// as zero) and address range checks. Uses lsie_pkg and lsie_ram.
`default_nettype none

module lsie_dmem (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lsie_pkg::mem_req_t req,
    output logic [31:0]             rd_data
);

    logic [lsie_pkg::MEM_DEPTH-1:0] vld_reg;
    logic                           rd_ok_reg;
    logic                           rd_in_range;
    logic                           wr_in_range;
    logic [lsie_pkg::MEM_AW-1:0]    rd_idx;
    logic [lsie_pkg::MEM_AW-1:0]    wr_idx;
    logic [31:0]                    ram_q;

    // range checks and indexes
    assign rd_in_range = req.rd_addr < lsie_pkg::MEM_DEPTH_W;
    assign wr_in_range = req.wr_addr < lsie_pkg::MEM_DEPTH_W;
    assign rd_idx      = req.rd_addr[lsie_pkg::MEM_AW-1:0];
    assign wr_idx      = req.wr_addr[lsie_pkg::MEM_AW-1:0];

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en && wr_in_range)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    // read qualifier follows the ram read latency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else if (req.rd_en)
        begin
            rd_ok_reg <= rd_in_range && vld_reg[rd_idx];
        end
    end

    lsie_ram #(
        .WIDTH (32),
        .DEPTH (lsie_pkg::MEM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en && wr_in_range),
        .wr_addr (wr_idx),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (rd_idx),
        .rd_data (ram_q)
    );

    // out of range or never written reads as zero
    assign rd_data = rd_ok_reg ? ram_q : 32'd0;

endmodule

`default_nettype wire

// File: hdl/lsie_core.sv
// lsie_core: instruction sequencer; reads operands from data memory, executes,
// writes back and updates pc and compare flag. Uses lsie_pkg and lsie_dmem.
`default_nettype none

module lsie_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [10:0]     program_length,
    input  wire logic            item_valid,
    input  wire lsie_pkg::item_t item_in,
    output logic                 item_take,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output lsie_pkg::res_t       res
);

    lsie_pkg::state_t   state_reg, state_next;
    logic [31:0]        pc_reg, pc_next;
    logic               flag_reg, flag_next;
    lsie_pkg::item_t    item_reg;
    logic [31:0]        cur_reg;
    logic [31:0]        src_reg;
    logic [31:0]        grn_reg;
    logic [31:0]        blu_reg;
    logic [31:0]        prod_reg;

    lsie_pkg::mem_req_t req;
    logic [31:0]        rd_data;
    logic [31:0]        src_val;
    logic               led_ind;
    logic               halt_now;
    logic               halt_after;
    logic               jmp_taken;
    logic [31:0]        pc_base;
    logic [31:0]        pc_addend;
    logic [31:0]        pc_sum;
    logic               commit;

    lsie_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    assign led_ind = (item_reg.func == lsie_pkg::FN_LED) && item_reg.indirect;
    assign src_val = item_reg.indirect ? rd_data : 32'(item_reg.operand);

    // halt test on the current pc
    assign halt_now = !((pc_reg < lsie_pkg::PROG_DEPTH_W) &&
                        (pc_reg < {21'd0, program_length}));

    // next pc: one adder, base + addend + 1 covers every jump form
    assign jmp_taken = !item_reg.conditional || flag_reg;
    always_comb
    begin
        pc_base   = pc_reg;
        pc_addend = 32'd0;
        case (item_reg.func)
            lsie_pkg::FN_JMP:
            begin
                if (jmp_taken)
                begin
                    pc_addend = item_reg.forward ? src_reg : ~src_reg;
                end
            end
            lsie_pkg::FN_LNJMP:
            begin
                pc_addend = 32'(item_reg.operand);
            end
            lsie_pkg::FN_ABSJMP:
            begin
                pc_base   = 32'd0;
                pc_addend = 32'(item_reg.operand);
            end
            default:
            begin
                pc_addend = 32'd0;
            end
        endcase
    end
    assign pc_sum     = pc_base + pc_addend + 32'd1;
    assign halt_after = !((pc_sum < lsie_pkg::PROG_DEPTH_W) &&
                          (pc_sum < {21'd0, program_length}));

    // state register and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsie_pkg::ST_IDLE;
            pc_reg    <= 32'd0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            flag_reg  <= flag_next;
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lsie_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_reg <= item_in;
                end
            end
            lsie_pkg::ST_RD1:
            begin
                cur_reg <= rd_data;
            end
            lsie_pkg::ST_RD2:
            begin
                src_reg  <= src_val;
                prod_reg <= cur_reg * src_val;
            end
            lsie_pkg::ST_RD3:
            begin
                grn_reg <= rd_data;
            end
            lsie_pkg::ST_RD4:
            begin
                blu_reg <= rd_data;
            end
            default:
            begin
            end
        endcase
    end

    // next state, memory requests and result
    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        flag_next   = flag_reg;
        item_take   = 1'b0;
        res_valid   = 1'b0;
        commit      = 1'b0;
        req         = '0;
        res         = '0;

        case (state_reg)
            lsie_pkg::ST_IDLE:
            begin
                // destination word read first
                req.rd_en   = item_valid;
                req.rd_addr = {24'd0, item_in.target};
                if (item_valid)
                begin
                    item_take  = 1'b1;
                    state_next = lsie_pkg::ST_RD1;
                end
            end
            lsie_pkg::ST_RD1:
            begin
                // source word, or red level address for indirect led
                req.rd_en   = 1'b1;
                req.rd_addr = led_ind ? {24'd0, item_reg.red} : 32'(item_reg.operand);
                state_next  = lsie_pkg::ST_RD2;
            end
            lsie_pkg::ST_RD2:
            begin
                req.rd_en   = led_ind;
                req.rd_addr = {24'd0, item_reg.green};
                state_next  = led_ind ? lsie_pkg::ST_RD3 : lsie_pkg::ST_FIN;
            end
            lsie_pkg::ST_RD3:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = {24'd0, item_reg.blue};
                state_next  = lsie_pkg::ST_RD4;
            end
            lsie_pkg::ST_RD4:
            begin
                state_next = lsie_pkg::ST_FIN;
            end
            lsie_pkg::ST_FIN:
            begin
                res_valid = 1'b1;
                commit    = res_ready && !halt_now;
                if (halt_now)
                begin
                    res.next_pc = pc_reg[9:0];
                    res.halted  = 1'b1;
                end
                else
                begin
                    res.next_pc = pc_sum[9:0];
                    res.halted  = halt_after;
                    case (item_reg.func)
                        lsie_pkg::FN_LED:
                        begin
                            res.led_write = 1'b1;
                            if (item_reg.indirect)
                            begin
                                res.led_index = cur_reg[7:0];
                                res.led_red   = src_reg[7:0];
                                res.led_green = grn_reg[7:0];
                                res.led_blue  = blu_reg[7:0];
                            end
                            else
                            begin
                                res.led_index = item_reg.target;
                                res.led_red   = item_reg.red;
                                res.led_green = item_reg.green;
                                res.led_blue  = item_reg.blue;
                            end
                        end
                        lsie_pkg::FN_CMP:
                        begin
                            if (commit)
                            begin
                                flag_next = item_reg.indirect ?
                                    ($signed(item_reg.operand) < $signed(cur_reg)) :
                                    ($signed(cur_reg) < $signed(item_reg.operand));
                            end
                        end
                        lsie_pkg::FN_STORE:
                        begin
                            req.wr_en   = commit;
                            req.wr_data = src_reg;
                        end
                        lsie_pkg::FN_ADD:
                        begin
                            req.wr_en   = commit;
                            req.wr_data = cur_reg + src_reg;
                        end
                        lsie_pkg::FN_SUB:
                        begin
                            req.wr_en   = commit;
                            req.wr_data = cur_reg - src_reg;
                        end
                        lsie_pkg::FN_MUL:
                        begin
                            req.wr_en   = commit;
                            req.wr_data = prod_reg;
                        end
                        lsie_pkg::FN_DBG:
                        begin
                            res.debug_valid = 1'b1;
                            res.debug_value = $signed(cur_reg);
                        end
                        lsie_pkg::FN_SHOW:
                        begin
                            res.show_strip = 1'b1;
                        end
                        lsie_pkg::FN_SLEEP:
                        begin
                            res.sleep_ticks = src_reg * lsie_pkg::SLEEP_SCALE;
                        end
                        lsie_pkg::FN_RAND:
                        begin
                            req.wr_en   = commit;
                            req.wr_data = {24'd0, item_reg.random_value};
                        end
                        default:
                        begin
                        end
                    endcase
                end
                req.wr_addr = {24'd0, item_reg.target};
                if (commit)
                begin
                    pc_next = pc_sum;
                end
                if (res_ready)
                begin
                    state_next = lsie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsie_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/led_sequencer_instruction_execute_top.sv
// led_sequencer_instruction_execute_top: instruction input buffer, config
// register, sequencer core and result register. Uses lsie_pkg, lsie_if, lsie_core.
//
//   channel  dir  handshake     word
//   cfg      in   valid/ready   program_length, 11 bits
//   item     in   valid/ready   one instruction
//   result   out  valid/ready   one result per instruction
//
// An instruction passes through states IDLE, RD1, RD2 and FIN (plus RD3 and RD4
// for indirect LED), set by the one read port of the data memory: one operand
// read per cycle, then a final state to execute and write back. A one-word input
// buffer takes the next instruction while the current one executes; a result
// register holds the finished word; a result stall only holds the core in FIN.
// Reset: pc, compare flag and program_length clear; memory entries read as
// zero until written (valid bits), so no clearing pass is needed.
`default_nettype none

module led_sequencer_instruction_execute_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lsie_cfg_if.sink      cfg,
    lsie_item_if.sink     item,
    lsie_result_if.source result
);

    logic [10:0]     prog_len_reg;
    logic            buf_valid_reg;
    lsie_pkg::item_t buf_reg;
    logic            out_valid_reg;
    lsie_pkg::res_t  out_reg;

    lsie_pkg::item_t item_word;
    logic            item_take;
    logic            res_valid;
    logic            res_ready;
    lsie_pkg::res_t  res;

    // config register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg <= 11'd0;
        end
        else if (cfg.valid)
        begin
            prog_len_reg <= cfg.data;
        end
    end

    // input buffer
    assign item_word.func         = item.func;
    assign item_word.indirect     = item.indirect;
    assign item_word.target       = item.target;
    assign item_word.operand      = item.operand;
    assign item_word.red          = item.red;
    assign item_word.green        = item.green;
    assign item_word.blue         = item.blue;
    assign item_word.forward      = item.forward;
    assign item_word.conditional  = item.conditional;
    assign item_word.random_value = item.random_value;
    assign item.ready             = !buf_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
        end
        else if (item.valid && !buf_valid_reg)
        begin
            buf_valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && !buf_valid_reg)
        begin
            buf_reg <= item_word;
        end
    end

    lsie_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .program_length (prog_len_reg),
        .item_valid     (buf_valid_reg),
        .item_in        (buf_reg),
        .item_take      (item_take),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    // result register
    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.next_pc     = out_reg.next_pc;
    assign result.halted      = out_reg.halted;
    assign result.led_write   = out_reg.led_write;
    assign result.led_index   = out_reg.led_index;
    assign result.led_red     = out_reg.led_red;
    assign result.led_green   = out_reg.led_green;
    assign result.led_blue    = out_reg.led_blue;
    assign result.show_strip  = out_reg.show_strip;
    assign result.sleep_ticks = out_reg.sleep_ticks;
    assign result.debug_valid = out_reg.debug_valid;
    assign result.debug_value = out_reg.debug_value;

endmodule

`default_nettype wire
